@@ src/bfiq_pkg.sv @@
// Shared types and constants for the Bloom filter insert/query core.
package bfiq_pkg;

    localparam int MAX_FILTER_BYTES = 1024;
    localparam int MAX_KEY_LEN      = 4095;
    localparam int ADDR_W           = $clog2(MAX_FILTER_BYTES);
    localparam int FB_W             = 11;
    localparam int PC_W             = 8;
    localparam int KLEN_W           = 12;
    localparam int BITS_W           = ADDR_W + 4;
    localparam int CFG_DATA_W       = 11;
    localparam int CFG_IDX_W        = 1;
    localparam int DIV_STEPS        = 32;

    localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
    localparam logic [31:0] HASH_MULT = 32'hc6a4a793;
    localparam logic [PC_W-1:0] PROBE_LIMIT = 8'd30;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FIN_MUL,
        ST_FIN_XOR,
        ST_DIV,
        ST_READ,
        ST_WAIT,
        ST_CHECK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start_clear;
        logic start_div;
        logic mem_read;
        logic mem_write;
        logic next_probe;
        logic fin_mul;
        logic fin_xor;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic bit_set;
        logic last_probe;
        logic need_tail;
        logic skip_probes;
    } t_status;

endpackage

@@ src/bfiq_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface bfiq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] key_byte;
    logic [11:0] key_length;
    logic       last;
    modport source (output valid, output opcode, output key_byte, output key_length,
                    output last, input ready);
    modport sink (input valid, input opcode, input key_byte, input key_length,
                  input last, output ready);
endinterface

interface bfiq_res_if;
    logic       valid;
    logic       ready;
    logic       may_contain;
    logic [1:0] op_kind;
    modport source (output valid, output may_contain, output op_kind, input ready);
    modport sink (input valid, input may_contain, input op_kind, output ready);
endinterface

@@ src/bfiq_ram.sv @@
// Generic single-port RAM with registered read.
module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/bfiq_ctrl.sv @@
// Sequencer for key finish, probe loop, store clear and result hand-off.
module bfiq_ctrl
    import bfiq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_end_key,
    input  logic    i_end_clear,
    input  logic    i_is_insert,
    input  t_status i_status,
    input  logic    i_res_ready,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_res_valid,
    output logic    o_res_bit
);
    t_state r_state, n_state;
    logic   r_ins, r_res, n_res, r_init;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_end_clear) n_state = ST_CLEAR;
                else if (i_end_key) n_state = ST_FIN_MUL;
            end
            ST_CLEAR:   if (i_status.clear_done) n_state = r_init ? ST_OUT : ST_IDLE;
            // last byte is absorbed by now, so the tail test is current
            ST_FIN_MUL: n_state = i_status.need_tail ? ST_FIN_XOR : ST_DIV;
            ST_FIN_XOR: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.skip_probes) n_state = ST_OUT;
                else if (i_status.div_done) n_state = ST_READ;
            end
            ST_READ:  n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_CHECK;
            ST_CHECK: begin
                if (!r_ins && !i_status.bit_set) n_state = ST_OUT;
                else if (i_status.last_probe) n_state = ST_OUT;
                else n_state = ST_DIV;
            end
            ST_OUT:   if (i_res_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_res = r_res;
        case (r_state)
            ST_IDLE: begin
                o_cmd.start_clear = i_end_clear;
                n_res = 1'b1;
            end
            ST_FIN_MUL: begin
                if (i_status.need_tail) o_cmd.fin_mul = 1'b1;
                else o_cmd.start_div = 1'b1;
            end
            ST_FIN_XOR: begin
                o_cmd.fin_xor = 1'b1;
                o_cmd.start_div = 1'b1;
            end
            ST_READ: o_cmd.mem_read = 1'b1;
            ST_CHECK: begin
                o_cmd.mem_write = r_ins;
                if (!r_ins && !i_status.bit_set) n_res = 1'b0;
                else if (!i_status.last_probe) begin
                    o_cmd.next_probe = 1'b1;
                    o_cmd.start_div = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_init  <= 1'b0;
            r_ins   <= 1'b0;
            r_res   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (r_state == ST_IDLE) r_ins <= i_is_insert;
            if (r_state == ST_IDLE && i_end_clear) r_init <= 1'b1;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_OUT);
    assign o_res_bit   = r_res;

`ifndef NO_ASSERTIONS
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !i_res_ready) |=> (r_state == ST_OUT))
        else $error("result dropped while stalled");
    a_write_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_write |-> r_ins)
        else $error("write during query");
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> o_busy)
        else $error("busy flag low during probe");
`endif
endmodule

@@ src/bfiq_dp.sv @@
// Hash accumulator, probe modulo unit, clear sweep and filter store.
module bfiq_dp
    import bfiq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_en,
    input  logic [7:0]        i_key_byte,
    input  logic [KLEN_W-1:0] i_key_length,
    input  logic              i_drop,
    input  logic              i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd              i_cmd,
    output t_status           o_status
);
    logic [31:0]       r_hash, r_delta, r_probe_h, r_rem, r_prod;
    logic [23:0]       r_tail;
    logic [KLEN_W-1:0] r_pos;
    logic [FB_W-1:0]   r_fb;
    logic [PC_W-1:0]   r_pc, r_idx;
    logic [5:0]        r_div_cnt;
    logic              r_div_busy;
    logic [ADDR_W:0]   r_clr;
    logic [BITS_W-1:0] r_bits;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_rd, mem_wd, bit_mask;
    logic              mem_we;
    logic [31:0]       seed_h, word_h, word_m, fin_h;
    logic [32:0]       rem_sh;
    logic [1:0]        lane;
    logic [FB_W-1:0]   fb_sat;

    assign fb_sat = (r_fb > FB_W'(MAX_FILTER_BYTES)) ? FB_W'(MAX_FILTER_BYTES) : r_fb;
    assign lane   = r_pos[1:0];
    assign seed_h = (r_pos == '0) ? (HASH_SEED ^ (32'(i_key_length) * HASH_MULT)) : r_hash;
    // a full word only closes at lane 3, where the hash is already seeded
    assign word_h = r_hash + {i_key_byte, r_tail};
    assign word_m = word_h * HASH_MULT;
    assign fin_h  = r_prod ^ (r_prod >> 24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_tail <= '0;
            r_pos  <= '0;
            r_fb   <= FB_W'(8);
            r_pc   <= PC_W'(6);
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_FILTER_BYTES) r_fb <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_PROBE_COUNT) r_pc <= i_cfg_data[PC_W-1:0];
            if (i_drop) begin
                r_hash <= '0;
                r_tail <= '0;
                r_pos  <= '0;
            end else if (i_byte_en) begin
                if (r_pos < i_key_length && r_pos < KLEN_W'(MAX_KEY_LEN)) begin
                    if (lane == 2'd3) begin
                        r_hash <= word_m ^ (word_m >> 16);
                        r_tail <= '0;
                    end else begin
                        r_hash <= seed_h;
                        r_tail <= r_tail | (24'(i_key_byte) << {lane, 3'b000});
                    end
                    r_pos <= r_pos + 1'b1;
                end else begin
                    r_hash <= seed_h;
                end
            end
        end
    end

    // finish hash: add tail and multiply, then fold
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_mul) r_prod <= (r_hash + 32'(r_tail)) * HASH_MULT;
    end

    // restoring remainder, one bit per cycle
    assign rem_sh = {r_rem, r_probe_h[31 - r_div_cnt[4:0]]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
            r_idx      <= '0;
        end else begin
            if (i_cmd.start_div) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= '0;
                r_rem      <= '0;
            end else if (r_div_busy) begin
                r_rem <= (rem_sh >= 33'(r_bits)) ? 32'(rem_sh - 33'(r_bits)) : rem_sh[31:0];
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == 6'(DIV_STEPS - 1)) r_div_busy <= 1'b0;
            end
            if (i_cmd.start_div && !i_cmd.next_probe) r_idx <= '0;
            else if (i_cmd.next_probe) r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= {fb_sat, 3'b000};
        if (i_cmd.fin_xor) begin
            r_probe_h <= fin_h;
            r_delta   <= {fin_h[16:0], fin_h[31:17]};
        end else if (i_cmd.start_div && !i_cmd.next_probe) begin
            r_probe_h <= r_hash;
            r_delta   <= {r_hash[16:0], r_hash[31:17]};
        end else if (i_cmd.next_probe) begin
            r_probe_h <= r_probe_h + r_delta;
        end
    end

    // clear sweep over the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.start_clear) begin
            r_clr <= '0;
        end else if (!r_clr[ADDR_W]) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign bit_mask = 8'(1) << r_rem[2:0];
    assign mem_we   = !r_clr[ADDR_W] || i_cmd.mem_write;
    assign mem_addr = !r_clr[ADDR_W] ? r_clr[ADDR_W-1:0] : r_rem[ADDR_W+2:3];
    assign mem_wd   = !r_clr[ADDR_W] ? 8'h00 : (mem_rd | bit_mask);

    bfiq_ram #(.WIDTH(8), .DEPTH(MAX_FILTER_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wd),
        .o_rdata (mem_rd)
    );

    always_comb begin
        o_status.clear_done  = r_clr[ADDR_W];
        o_status.div_done    = !r_div_busy && !i_cmd.start_div;
        o_status.bit_set     = |(mem_rd & bit_mask);
        o_status.last_probe  = (r_idx + 1'b1 == r_pc);
        o_status.need_tail   = (r_pos[1:0] != 2'd0);
        o_status.skip_probes = (fb_sat == '0) || (r_pc == '0) || (r_pc > PROBE_LIMIT);
    end

`ifndef NO_ASSERTIONS
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_div_busy && i_cmd.mem_read) |-> (r_rem < 32'(r_bits)))
        else $error("probe index out of range");
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr[ADDR_W] |-> !i_cmd.mem_write)
        else $error("insert during clear sweep");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> (r_div_cnt < 6'(DIV_STEPS)))
        else $error("divider count overrun");
`endif
endmodule

@@ src/bloom_filter_insert_query_core.sv @@
// Top level of the Bloom filter insert/query core.
// Requests arrive on i_req, one key byte each, tagged insert or query, with
// the key length on every byte; a clear request zeroes the filter store.
// A result (may_contain, op_kind) leaves on o_res for every request with last
// set and for every clear; opcode 3 is dropped with no result.
// Non-final key bytes are taken one per cycle. A key end then passes the
// finish step (a partial tail word, when there is one, is added, multiplied
// and folded in), then each probe (a bit-serial 32-step remainder by eight
// times filter_bytes, then read, wait and, for an insert, read-modify-write
// of one store byte) and then the result step; a query stops at its first
// clear bit, and when the probes are skipped the result follows with no probe.
// A clear request sweeps the 1024-byte store, one byte a cycle, and gives its
// result once the sweep is done.
// After reset the store is swept the same way before the first request is
// taken; configuration writes are taken throughout.
// While the receiver stalls, the result holds on o_res and no request is
// accepted. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data.
module bloom_filter_insert_query_core
    import bfiq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bfiq_req_if.sink              i_req,
    bfiq_res_if.source            o_res
);
    t_cmd    cmd;
    t_status status;
    logic    busy, res_valid, res_bit, acc, end_key, end_clear;
    logic [1:0] r_op;

    assign i_req.ready = !busy;
    assign acc       = i_req.valid && i_req.ready;
    assign end_clear = acc && (i_req.opcode == OP_CLEAR);
    assign end_key   = acc && i_req.last &&
                       (i_req.opcode == OP_INSERT || i_req.opcode == OP_QUERY);

    always_ff @(posedge i_clk) begin
        if (acc && (end_clear || end_key)) r_op <= i_req.opcode;
    end

    bfiq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_en    (acc && (i_req.opcode == OP_INSERT || i_req.opcode == OP_QUERY)),
        .i_key_byte   (i_req.key_byte),
        .i_key_length (i_req.key_length),
        .i_drop       (end_clear || (status.need_tail ? cmd.fin_xor : cmd.start_div)
                       && !cmd.next_probe),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_status     (status)
    );

    bfiq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_end_key   (end_key),
        .i_end_clear (end_clear),
        .i_is_insert (i_req.opcode == OP_INSERT),
        .i_status    (status),
        .i_res_ready (o_res.ready),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res_bit   (res_bit)
    );

    assign o_res.valid       = res_valid;
    assign o_res.may_contain = res_bit;
    assign o_res.op_kind     = r_op;
endmodule
